FILE: hdl/cbe_pkg.sv
// Shared constants, codes and command/status types of the Bezier easing unit.
package cbe_pkg;

    // Curve range is 2^RANGE_BITS; Newton passes are bounded by MAX_ITERATIONS
    localparam int RANGE_BITS     = 10;
    localparam int MAX_ITERATIONS = 16;
    localparam int TOLERANCE      = 50;

    // Field widths
    localparam int PROG_W     = 11;
    localparam int X_W        = 11;
    localparam int Y_W        = 16;
    localparam int T_W        = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Narrow multiplier operand: holds t, R - t and every control coefficient
    localparam int OP_W   = 17;
    // Products are only needed modulo 2^PROD_W (top kept bits sit just below)
    localparam int PROD_W = 3 * RANGE_BITS + T_W;
    // x - x(t) and the scaled Newton dividend
    localparam int DIFF_W = 18;
    localparam int DVD_W  = DIFF_W + RANGE_BITS;
    // Sequencer counters
    localparam int PASS_W = $clog2(MAX_ITERATIONS + 1);
    localparam int STEP_W = 4;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_X1 = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y1 = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_X2 = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y2 = 2'd3;

    // Register reset values
    localparam logic [X_W-1:0] X1_RESET = 11'd0;
    localparam logic [Y_W-1:0] Y1_RESET = 16'd0;
    localparam logic [X_W-1:0] X2_RESET = 11'd1024;
    localparam logic [Y_W-1:0] Y2_RESET = 16'd1024;

    // Multiplier operand selects
    typedef enum logic [2:0] {
        A_PROD,
        A_T,
        A_C1,
        A_C2,
        A_D1,
        A_D2
    } t_a_sel;

    typedef enum logic {
        B_T,
        B_INV
    } t_b_sel;

    // Accumulator operations on the last product
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD3,
        ACC_ADD3,
        ACC_ADD6,
        ACC_ADDR
    } t_acc_op;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    mul_en;
        t_a_sel  a_sel;
        t_b_sel  b_sel;
        t_acc_op acc_op;
        logic    use_y;
        logic    latch_xt;
        logic    latch_d;
        logic    latch_y;
        logic    div_start;
        logic    t_update;
        logic    out_load;
        logic    out_conv;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic tol_ok;
        logic d_zero;
        logic div_done;
    } t_dp_stat;

endpackage

FILE: hdl/cbe_div.sv
// Restoring divider for the Newton step, one quotient bit per cycle.
module cbe_div
    import cbe_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic signed [T_W-1:0]   i_divisor,
    output logic                    o_done,
    output logic        [T_W-1:0]   o_quot
);

    localparam int DV_W  = T_W + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DVD_W-1:0] r_q;
    logic [DV_W-1:0]  r_rem;
    logic [DV_W-1:0]  r_dv;
    logic             r_neg;

    logic [DVD_W-1:0] w_dvd_mag;
    logic [DV_W-1:0]  w_dv_ext;
    logic [DV_W-1:0]  w_dv_mag;
    logic [DV_W:0]    w_trial;
    logic [DV_W:0]    w_sub;
    logic             w_ge;

    // operand magnitudes, sign of the quotient kept apart
    assign w_dvd_mag = i_dividend[DVD_W-1] ? (~i_dividend + DVD_W'(1)) : i_dividend;
    assign w_dv_ext  = {i_divisor[T_W-1], i_divisor};
    assign w_dv_mag  = w_dv_ext[DV_W-1] ? (~w_dv_ext + DV_W'(1)) : w_dv_ext;

    // shift in the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_q[DVD_W-1]};
    assign w_sub   = w_trial - {1'b0, r_dv};
    assign w_ge    = (w_trial >= {1'b0, r_dv});

    // control: bit counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    // quotient shifts into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_dvd_mag;
            r_rem <= '0;
            r_dv  <= w_dv_mag;
            r_neg <= i_dividend[DVD_W-1] ^ i_divisor[T_W-1];
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DV_W-1:0] : w_trial[DV_W-1:0];
        end
    end

    // truncating toward zero; only the low bits are needed, wrap is intended
    assign o_quot = r_neg ? (~r_q[T_W-1:0] + T_W'(1)) : r_q[T_W-1:0];
    assign o_done = r_done;

endmodule

FILE: hdl/cbe_datapath.sv
// Datapath: control registers, shared multiplier, accumulator, tolerance check and divider.
module cbe_datapath
    import cbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [PROG_W-1:0]     i_progress,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic [Y_W-1:0]        o_eased_value,
    output logic                  o_converged
);

    localparam logic [OP_W-1:0] R_OP = OP_W'(1 << RANGE_BITS);
    localparam logic signed [DIFF_W-1:0] TOL_P = DIFF_W'(TOLERANCE);
    localparam logic signed [DIFF_W-1:0] TOL_N = DIFF_W'(-TOLERANCE);

    // control points
    logic [X_W-1:0] r_x1;
    logic [Y_W-1:0] r_y1;
    logic [X_W-1:0] r_x2;
    logic [Y_W-1:0] r_y2;

    // working registers
    logic [PROG_W-1:0] r_x;
    logic [T_W-1:0]    r_t;
    logic [T_W-1:0]    r_xt;
    logic [T_W-1:0]    r_d;
    logic [Y_W-1:0]    r_y;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_acc;
    logic [Y_W-1:0]    r_out_y;
    logic              r_out_conv;

    logic [OP_W-1:0]                w_x1e;
    logic [OP_W-1:0]                w_x2e;
    logic [OP_W-1:0]                w_c1;
    logic [OP_W-1:0]                w_c2;
    logic [OP_W-1:0]                w_t_op;
    logic [OP_W-1:0]                w_inv;
    logic [OP_W-1:0]                w_small;
    logic signed [PROD_W-1:0]       w_a;
    logic signed [OP_W-1:0]         w_b;
    logic signed [PROD_W+OP_W-1:0]  w_full;
    logic signed [DIFF_W-1:0]       w_diff;
    logic [T_W-1:0]                 w_quot;
    logic                           w_div_done;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= X1_RESET;
            r_y1 <= Y1_RESET;
            r_x2 <= X2_RESET;
            r_y2 <= Y2_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_X1:  r_x1 <= i_cfg_wdata[X_W-1:0];
                CFG_Y1:  r_y1 <= i_cfg_wdata[Y_W-1:0];
                CFG_X2:  r_x2 <= i_cfg_wdata[X_W-1:0];
                CFG_Y2:  r_y2 <= i_cfg_wdata[Y_W-1:0];
                default: ;
            endcase
        end
    end

    // coefficients: x controls are unsigned, y controls signed
    assign w_x1e  = {{(OP_W-X_W){1'b0}}, r_x1};
    assign w_x2e  = {{(OP_W-X_W){1'b0}}, r_x2};
    assign w_c1   = i_cmd.use_y ? {{(OP_W-Y_W){r_y1[Y_W-1]}}, r_y1} : w_x1e;
    assign w_c2   = i_cmd.use_y ? {{(OP_W-Y_W){r_y2[Y_W-1]}}, r_y2} : w_x2e;
    assign w_t_op = {{(OP_W-T_W){r_t[T_W-1]}}, r_t};
    assign w_inv  = R_OP - w_t_op;

    // operand select
    always_comb begin
        case (i_cmd.a_sel)
            A_T:     w_small = w_t_op;
            A_C1:    w_small = w_c1;
            A_C2:    w_small = w_c2;
            A_D1:    w_small = w_x2e - w_x1e;
            A_D2:    w_small = R_OP - w_x2e;
            default: w_small = w_t_op;
        endcase
        if (i_cmd.a_sel == A_PROD) begin
            w_a = r_prod;
        end else begin
            w_a = {{(PROD_W-OP_W){w_small[OP_W-1]}}, w_small};
        end
        w_b = (i_cmd.b_sel == B_INV) ? w_inv : w_t_op;
    end

    // shared multiplier, kept modulo 2^PROD_W
    assign w_full = w_a * w_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_full[PROD_W-1:0];
        end
    end

    // weighted sum of the chain products
    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            ACC_LOAD3: r_acc <= r_prod + (r_prod << 1);
            ACC_ADD3:  r_acc <= r_acc + r_prod + (r_prod << 1);
            ACC_ADD6:  r_acc <= r_acc + (r_prod << 1) + (r_prod << 2);
            ACC_ADDR:  r_acc <= r_acc + (r_prod << RANGE_BITS);
            default:   ;
        endcase
    end

    // target, parameter t and the kept result bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_progress;
            r_t <= {{(T_W-PROG_W){1'b0}}, i_progress};
        end else if (i_cmd.t_update) begin
            r_t <= r_t + w_quot;
        end
        if (i_cmd.latch_xt) begin
            r_xt <= r_acc[3*RANGE_BITS +: T_W];
        end
        if (i_cmd.latch_d) begin
            r_d <= r_acc[2*RANGE_BITS +: T_W];
        end
        if (i_cmd.latch_y) begin
            r_y <= r_acc[3*RANGE_BITS +: Y_W];
        end
        if (i_cmd.out_load) begin
            r_out_y    <= r_y;
            r_out_conv <= i_cmd.out_conv;
        end
    end

    // distance to target
    assign w_diff = {{(DIFF_W-PROG_W){1'b0}}, r_x} - {{(DIFF_W-T_W){r_xt[T_W-1]}}, r_xt};

    // Newton step: (x - x(t)) * R / slope
    cbe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_diff, {RANGE_BITS{1'b0}}}),
        .i_divisor  (r_d),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_stat.tol_ok   = (w_diff <= TOL_P) && (w_diff >= TOL_N);
    assign o_stat.d_zero   = (r_d == '0);
    assign o_stat.div_done = w_div_done;

    assign o_eased_value = r_out_y;
    assign o_converged   = r_out_conv;

endmodule

FILE: hdl/cbe_ctrl.sv
// Controller: sequences curve, slope, division and output for each input word.
module cbe_ctrl
    import cbe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CURVE  = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SLOPE  = 3'd3;
    localparam logic [2:0] S_DCHK   = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_YCURVE = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    localparam logic [STEP_W-1:0] CURVE_LAST = STEP_W'(9);
    localparam logic [STEP_W-1:0] SLOPE_LAST = STEP_W'(7);

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [PASS_W-1:0] r_pass,  n_pass;
    logic              r_conv,  n_conv;
    logic              r_out_valid, n_out_valid;

    t_dp_cmd w_curve;
    t_dp_cmd w_slope;

    // curve steps: 3*c1*t*inv^2 + 3*c2*t^2*inv + R*t^3
    always_comb begin
        w_curve = '0;
        case (r_step)
            STEP_W'(0): begin
                w_curve.mul_en = 1'b1; w_curve.a_sel = A_C1;   w_curve.b_sel = B_T;
            end
            STEP_W'(1), STEP_W'(2), STEP_W'(5): begin
                w_curve.mul_en = 1'b1; w_curve.a_sel = A_PROD; w_curve.b_sel = B_INV;
            end
            STEP_W'(3): begin
                w_curve.mul_en = 1'b1; w_curve.a_sel = A_C2;   w_curve.b_sel = B_T;
                w_curve.acc_op = ACC_LOAD3;
            end
            STEP_W'(4), STEP_W'(7): begin
                w_curve.mul_en = 1'b1; w_curve.a_sel = A_PROD; w_curve.b_sel = B_T;
            end
            STEP_W'(6): begin
                w_curve.mul_en = 1'b1; w_curve.a_sel = A_T;    w_curve.b_sel = B_T;
                w_curve.acc_op = ACC_ADD3;
            end
            STEP_W'(8): begin
                w_curve.acc_op = ACC_ADDR;
            end
            default: ;
        endcase
    end

    // slope steps: 3*c1*inv^2 + 6*(c2-c1)*inv*t + 3*(R-c2)*t^2
    always_comb begin
        w_slope = '0;
        case (r_step)
            STEP_W'(0): begin
                w_slope.mul_en = 1'b1; w_slope.a_sel = A_C1;   w_slope.b_sel = B_INV;
            end
            STEP_W'(1): begin
                w_slope.mul_en = 1'b1; w_slope.a_sel = A_PROD; w_slope.b_sel = B_INV;
            end
            STEP_W'(2): begin
                w_slope.mul_en = 1'b1; w_slope.a_sel = A_D1;   w_slope.b_sel = B_INV;
                w_slope.acc_op = ACC_LOAD3;
            end
            STEP_W'(3), STEP_W'(5): begin
                w_slope.mul_en = 1'b1; w_slope.a_sel = A_PROD; w_slope.b_sel = B_T;
            end
            STEP_W'(4): begin
                w_slope.mul_en = 1'b1; w_slope.a_sel = A_D2;   w_slope.b_sel = B_T;
                w_slope.acc_op = ACC_ADD6;
            end
            STEP_W'(6): begin
                w_slope.acc_op = ACC_ADD3;
            end
            default: ;
        endcase
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_pass      = r_pass;
        n_conv      = r_conv;
        o_cmd       = '0;
        o_in_ready  = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_pass     = '0;
                    n_step     = '0;
                    n_state    = S_CURVE;
                end
            end
            S_CURVE: begin
                o_cmd  = w_curve;
                n_step = r_step + STEP_W'(1);
                if (r_step == CURVE_LAST) begin
                    o_cmd.latch_xt = 1'b1;
                    n_step         = '0;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.tol_ok) begin
                    n_conv  = 1'b1;
                    n_state = S_YCURVE;
                end else if (r_pass == PASS_W'(MAX_ITERATIONS)) begin
                    n_conv  = 1'b0;
                    n_state = S_YCURVE;
                end else begin
                    n_state = S_SLOPE;
                end
            end
            S_SLOPE: begin
                o_cmd  = w_slope;
                n_step = r_step + STEP_W'(1);
                if (r_step == SLOPE_LAST) begin
                    o_cmd.latch_d = 1'b1;
                    n_step        = '0;
                    n_state       = S_DCHK;
                end
            end
            S_DCHK: begin
                if (i_stat.d_zero) begin
                    n_conv  = 1'b0;
                    n_state = S_YCURVE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.t_update = 1'b1;
                    n_pass         = r_pass + PASS_W'(1);
                    n_state        = S_CURVE;
                end
            end
            S_YCURVE: begin
                o_cmd       = w_curve;
                o_cmd.use_y = 1'b1;
                n_step      = r_step + STEP_W'(1);
                if (r_step == CURVE_LAST) begin
                    o_cmd.latch_y = 1'b1;
                    n_step        = '0;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_conv = r_conv;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.out_load;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_pass      <= '0;
            r_conv      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pass      <= n_pass;
            r_conv      <= n_conv;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass <= PASS_W'(MAX_ITERATIONS))
        else $error("pass count beyond limit");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.d_zero)
        else $error("division started with zero slope");

    a_update_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.t_update |-> i_stat.div_done)
        else $error("t updated before quotient ready");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten before taken");
`endif

endmodule

FILE: hdl/cubic_bezier_easing_unit.sv
// Cubic Bezier easing unit: top level with stream ports and configuration write port.
// Solves x(t) = progress by Newton iteration on a cubic Bezier easing curve with end
// points (0,0) and (R,R), R = 2^RANGE_BITS, and returns y(t) with a converged flag.
// One word is worked on at a time, on a single shared multiplier plus a bit-serial
// divider: the first x(t) is formed, then each Newton pass computes the slope, runs
// the 28-bit division and forms the new x(t), with at most 16 passes, and y(t) plus
// the output load come last. A new word is accepted while the previous result still
// waits in the output register. Control points must be written through the cfg port
// (index 0: x1, 1: y1, 2: x2, 3: y2) only while the unit is idle; the unit itself
// does not enforce this.
module cubic_bezier_easing_unit
    import cbe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [15:0]           i_s_axis_tdata,   // [10:0] progress, rest zero
    // output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [15:0]           o_m_axis_tdata,   // [15:0] eased_value
    output logic                  o_m_axis_tuser    // [0] converged
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    cbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    cbe_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_progress    (i_s_axis_tdata[PROG_W-1:0]),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_eased_value (o_m_axis_tdata),
        .o_converged   (o_m_axis_tuser)
    );

endmodule
